// ===== hw/rtl/lor_pkg.sv =====
// Package for the largest ones rectangle unit.
// Holds default sizes, register indexes, controller states and the command/status structs.
`default_nettype none

package lor_pkg;

  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 64;

  localparam int CFG_DATA_W  = 7;
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'b1;
  localparam logic [CFG_DATA_W-1:0]  GRID_SIZE_RESET = 7'd64;

  localparam int IN_DATA_W    = 8;
  localparam int OUT_DATA_W   = 40;
  localparam int TOP_ROW_W    = 6;
  localparam int RIGHT_COL_W  = 6;
  localparam int RECT_WIDTH_W = 7;
  localparam int RECT_HEIGHT_W = 7;
  localparam int RECT_AREA_W  = 13;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MOD,
    ST_COL,
    ST_RD,
    ST_EVAL,
    ST_CMP,
    ST_POPW,
    ST_MUL,
    ST_BEST,
    ST_OUT
  } lor_state_t;

  typedef struct packed {
    logic load;
    logic mod_start;
    logic mod_step;
    logic scan_init;
    logic col_init;
    logic rd;
    logic eval;
    logic pop;
    logic popw;
    logic push;
    logic mul;
    logic best;
    logic adv_row;
    logic next_col;
    logic out_load;
  } lor_cmd_t;

  typedef struct packed {
    logic width_wr;
    logic mod_done;
    logic pop_cond;
    logic pop_more;
    logic pass_down;
    logic r_last;
    logic c_last;
    logic out_busy;
  } lor_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lor_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module lor_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lor_ctrl.sv =====
// Controller FSM for the largest ones rectangle unit: load, width re-sync and column scans.
// Depends on lor_pkg.
`default_nettype none

module lor_ctrl
  import lor_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tlast,
  output logic             s_tready,
  input  wire lor_status_t status,
  output lor_cmd_t         cmd
);

  lor_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_LOAD: begin
        s_tready = !status.width_wr;
        if (status.width_wr) begin
          cmd.mod_start = 1'b1;
          state_next = ST_MOD;
        end else if (s_tvalid) begin
          cmd.load = 1'b1;
          if (s_tlast) begin
            cmd.scan_init = 1'b1;
            state_next = ST_COL;
          end
        end
      end
      ST_MOD: begin
        if (status.width_wr) begin
          cmd.mod_start = 1'b1;
        end else if (status.mod_done) begin
          state_next = ST_LOAD;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      ST_COL: begin
        cmd.col_init = 1'b1;
        state_next = ST_RD;
      end
      ST_RD: begin
        cmd.rd = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (status.pop_cond) begin
          cmd.pop = 1'b1;
          if (status.pop_more) begin
            state_next = ST_POPW;
          end
        end else begin
          cmd.push = 1'b1;
          state_next = status.pass_down ? ST_MUL : ST_RD;
        end
      end
      ST_POPW: begin
        cmd.popw = 1'b1;
        state_next = ST_CMP;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_BEST;
      end
      ST_BEST: begin
        cmd.best = 1'b1;
        if (!status.r_last) begin
          cmd.adv_row = 1'b1;
          state_next = ST_RD;
        end else if (status.c_last) begin
          state_next = ST_OUT;
        end else begin
          cmd.next_col = 1'b1;
          state_next = ST_COL;
        end
      end
      ST_OUT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lor_datapath.sv =====
// Datapath: config registers, run-length store, column stack, edge store, best tracking.
// Depends on lor_pkg and lor_ram.
`default_nettype none

module lor_datapath
  import lor_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire lor_cmd_t               cmd,
  output lor_status_t                 status,
  input  wire logic                   cell_open,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_DATA_W-1:0]       m_tdata
);

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int VW    = $clog2(MAX_COLS + 1);
  localparam int HW    = $clog2(MAX_ROWS + 1);
  localparam int NCELL = MAX_COLS * MAX_ROWS;
  localparam int AD    = $clog2(NCELL);
  localparam int PW    = $clog2(NCELL + 1);
  localparam int SW    = RW + VW;

  logic [CFG_DATA_W-1:0] grid_width, grid_height;
  logic [VW-1:0] wc;
  logic [HW-1:0] hc;
  logic [PW-1:0] cells;

  logic [PW-1:0] load_pos, col_work;
  logic [VW-1:0] prev_run, run_new;
  logic          load_ok;

  logic [CW-1:0] c;
  logic [RW-1:0] r;
  logic [AD-1:0] addr;
  logic          pass_down;
  logic [HW-1:0] depth;
  logic [RW-1:0] top_row;
  logic [VW-1:0] top_val;
  logic [VW-1:0] cur_v, v_comb, lim;
  logic [RW-1:0] edge_row;
  logic [RW-1:0] cand_top;
  logic [HW-1:0] cand_ht;
  logic [PW-1:0] prod;

  logic [PW-1:0] best_area;
  logic [RW-1:0] best_r, b_top;
  logic [CW-1:0] b_col;
  logic [VW-1:0] b_w;
  logic [HW-1:0] b_h;

  logic [RW-1:0] o_top;
  logic [CW-1:0] o_col;
  logic [VW-1:0] o_w;
  logic [HW-1:0] o_h;
  logic [PW-1:0] o_area;

  logic [VW-1:0] run_rdata;
  logic [RW-1:0] up_rdata;
  logic [SW-1:0] stk_rdata;

  always_comb begin
    if (grid_width == '0) begin
      wc = VW'(1);
    end else if (32'(grid_width) > MAX_COLS) begin
      wc = VW'(MAX_COLS);
    end else begin
      wc = VW'(grid_width);
    end
    if (grid_height == '0) begin
      hc = HW'(1);
    end else if (32'(grid_height) > MAX_ROWS) begin
      hc = HW'(MAX_ROWS);
    end else begin
      hc = HW'(grid_height);
    end
  end

  assign cells   = PW'(wc) * PW'(hc);
  assign load_ok = load_pos < cells;

  always_comb begin
    if (!cell_open) begin
      run_new = '0;
    end else if (col_work == '0) begin
      run_new = VW'(1);
    end else if (prev_run == VW'(MAX_COLS)) begin
      run_new = prev_run;
    end else begin
      run_new = prev_run + VW'(1);
    end
  end

  assign lim = VW'(c) + VW'(1);

  always_comb begin
    if (PW'(addr) >= load_pos) begin
      v_comb = '0;
    end else if (run_rdata < lim) begin
      v_comb = run_rdata;
    end else begin
      v_comb = lim;
    end
  end

  always_comb begin
    if (pass_down) begin
      edge_row = (depth != '0) ? top_row - RW'(1) : RW'(hc - HW'(1));
    end else begin
      edge_row = (depth != '0) ? top_row + RW'(1) : '0;
    end
  end

  always_comb begin
    status.width_wr  = cfg_we && (cfg_index == REG_GRID_WIDTH);
    status.mod_done  = col_work < PW'(wc);
    status.pop_cond  = (depth != '0) && (top_val >= cur_v);
    status.pop_more  = depth > HW'(1);
    status.pass_down = pass_down;
    status.r_last    = pass_down ? (r == '0) : (r == RW'(hc - HW'(1)));
    status.c_last    = c == CW'(wc - VW'(1));
    status.out_busy  = m_tvalid && !m_tready;
  end

  lor_ram #(.WIDTH(VW), .DEPTH(NCELL)) u_run_ram (
    .clk   (clk),
    .we    (cmd.load && load_ok),
    .waddr (load_pos[AD-1:0]),
    .wdata (run_new),
    .re    (cmd.rd),
    .raddr (addr),
    .rdata (run_rdata)
  );

  lor_ram #(.WIDTH(RW), .DEPTH(MAX_ROWS)) u_up_ram (
    .clk   (clk),
    .we    (cmd.push && !pass_down),
    .waddr (r),
    .wdata (edge_row),
    .re    (cmd.rd && pass_down),
    .raddr (r),
    .rdata (up_rdata)
  );

  lor_ram #(.WIDTH(SW), .DEPTH(MAX_ROWS)) u_stack_ram (
    .clk   (clk),
    .we    (cmd.push && (depth != '0)),
    .waddr (RW'(depth - HW'(1))),
    .wdata ({top_row, top_val}),
    .re    (cmd.pop && (depth > HW'(1))),
    .raddr (RW'(depth - HW'(2))),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_SIZE_RESET;
      grid_height <= GRID_SIZE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_GRID_WIDTH) begin
        grid_width <= cfg_wdata;
      end else begin
        grid_height <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos <= '0;
      col_work <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.load && load_ok) begin
        load_pos <= load_pos + PW'(1);
        col_work <= (col_work + PW'(1) == PW'(wc)) ? '0 : col_work + PW'(1);
      end else if (cmd.mod_start) begin
        col_work <= load_pos;
      end else if (cmd.mod_step) begin
        col_work <= col_work - PW'(wc);
      end else if (cmd.out_load) begin
        load_pos <= '0;
        col_work <= '0;
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      prev_run <= run_new;
    end
    if (cmd.scan_init) begin
      c         <= '0;
      best_area <= '0;
      best_r    <= '0;
      b_top     <= '0;
      b_col     <= '0;
      b_w       <= '0;
      b_h       <= '0;
    end
    if (cmd.col_init) begin
      r         <= '0;
      addr      <= AD'(c);
      pass_down <= 1'b0;
      depth     <= '0;
    end
    if (cmd.eval) begin
      cur_v <= v_comb;
    end
    if (cmd.pop) begin
      depth <= depth - HW'(1);
    end
    if (cmd.popw) begin
      top_row <= stk_rdata[SW-1:VW];
      top_val <= stk_rdata[VW-1:0];
    end
    if (cmd.push) begin
      top_row <= r;
      top_val <= cur_v;
      if (pass_down) begin
        depth    <= depth + HW'(1);
        cand_top <= up_rdata;
        cand_ht  <= HW'(edge_row) - HW'(up_rdata) + HW'(1);
      end else if (r == RW'(hc - HW'(1))) begin
        pass_down <= 1'b1;
        depth     <= '0;
      end else begin
        depth <= depth + HW'(1);
        r     <= r + RW'(1);
        addr  <= addr + AD'(wc);
      end
    end
    if (cmd.mul) begin
      prod <= PW'(cur_v) * PW'(cand_ht);
    end
    if (cmd.best) begin
      if ((cur_v != '0) &&
          ((prod > best_area) || ((prod == best_area) && (r < best_r)))) begin
        best_area <= prod;
        best_r    <= r;
        b_top     <= cand_top;
        b_col     <= c;
        b_w       <= cur_v;
        b_h       <= cand_ht;
      end
    end
    if (cmd.adv_row) begin
      r    <= r - RW'(1);
      addr <= addr - AD'(wc);
    end
    if (cmd.next_col) begin
      c <= c + CW'(1);
    end
    if (cmd.out_load) begin
      o_top  <= b_top;
      o_col  <= b_col;
      o_w    <= b_w;
      o_h    <= b_h;
      o_area <= best_area;
    end
  end

  assign m_tdata = {1'b0, RECT_AREA_W'(o_area), RECT_HEIGHT_W'(o_h), RECT_WIDTH_W'(o_w),
                    RIGHT_COL_W'(o_col), TOP_ROW_W'(o_top)};

endmodule

`default_nettype wire

// ===== hw/rtl/largest_ones_rectangle_unit.sv =====
// Largest ones rectangle unit: one cell beat per cycle while loading, unless a grid-width
// write is being re-synced; after the last cell, each column is scanned upward then downward
// with a stack (per row: read, evaluate, pops, push; downward adds multiply and best check).
// Throughput is set by that scan sequencer over the run-length RAM's single read port.
// A result waits in the output register while the next grid loads.
// rst is synchronous: control, counters and config clear; the run-length RAM is not cleared.
`default_nettype none

module largest_ones_rectangle_unit
  import lor_pkg::*;
#(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_DATA_W-1:0]   s_tdata,   // [0] cell_open
  input  wire logic                   s_tlast,   // last_cell
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_DATA_W-1:0]       m_tdata,   // top_row, right_column, rect_width,
                                                 // rect_height, rect_area
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  lor_cmd_t    cmd;
  lor_status_t status;

  lor_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lor_datapath #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cell_open (s_tdata[0]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/lor_checker.sv =====
// Port-level checks for the largest ones rectangle unit, bound to the top level.
// Depends on lor_pkg.
`default_nettype none

module lor_checker
  import lor_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tvalid,
  input wire logic                   s_tready,
  input wire logic                   s_tlast,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_DATA_W-1:0]  m_tdata
);

  logic [13:0] area_calc;
  assign area_calc = 14'(m_tdata[18:12]) * 14'(m_tdata[25:19]);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat dropped or changed while stalled");

  a_scan_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input taken right after last cell");

  a_area: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> area_calc == 14'(m_tdata[38:26]))
    else $error("area differs from width times height");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[38:26] == '0) |-> m_tdata[25:0] == '0)
    else $error("empty grid result has nonzero fields");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind largest_ones_rectangle_unit lor_checker u_lor_checker (.*);

`default_nettype wire

// ===== sim/tb_largest_ones_rectangle_unit.sv =====
// Testbench for largest_ones_rectangle_unit: streams binary grids, checks each rectangle.
// A scoreboard class predicts the result of every grid; depends on lor_pkg and the unit's RTL.
`timescale 1ns / 100ps

import lor_pkg::*;

typedef struct packed {
  logic [RECT_AREA_W-1:0]   area;
  logic [RECT_HEIGHT_W-1:0] height;
  logic [RECT_WIDTH_W-1:0]  width;
  logic [RIGHT_COL_W-1:0]   column;
  logic [TOP_ROW_W-1:0]     top;
} rect_t;

class rect_scoreboard;
  logic [CFG_DATA_W-1:0] width_reg, height_reg;
  int unsigned run_len[DEF_MAX_ROWS*DEF_MAX_COLS];
  int unsigned cells_loaded;
  rect_t rect_q[$];
  int unsigned errors, rects_seen, nonzero_seen;

  function void clear();
    width_reg = GRID_SIZE_RESET;
    height_reg = GRID_SIZE_RESET;
    cells_loaded = 0;
    rect_q.delete();
  endfunction

  function int unsigned sat(logic [CFG_DATA_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == REG_GRID_WIDTH) width_reg = val;
    else if (idx == REG_GRID_HEIGHT) height_reg = val;
  endfunction

  function int unsigned run_of(int unsigned r, int unsigned c, int unsigned w);
    int unsigned idx, v;
    idx = r * w + c;
    if (idx >= cells_loaded) return 0;
    v = run_len[idx];
    return (v > c + 1) ? c + 1 : v;
  endfunction

  function rect_t largest_rect();
    int unsigned w, h, depth, v, ht, area, best, best_idx, idx;
    int unsigned stk[DEF_MAX_ROWS], up[DEF_MAX_ROWS], dn[DEF_MAX_ROWS];
    rect_t res;
    w = sat(width_reg, DEF_MAX_COLS);
    h = sat(height_reg, DEF_MAX_ROWS);
    res = '0;
    best = 0;
    best_idx = 0;
    for (int c = 0; c < w; c++) begin
      depth = 0;
      for (int r = 0; r < h; r++) begin
        v = run_of(r, c, w);
        while (depth > 0 && run_of(stk[depth-1], c, w) >= v) depth--;
        up[r] = depth ? stk[depth-1] + 1 : 0;
        stk[depth++] = r;
      end
      depth = 0;
      for (int r = h - 1; r >= 0; r--) begin
        v = run_of(r, c, w);
        while (depth > 0 && run_of(stk[depth-1], c, w) >= v) depth--;
        dn[r] = depth ? stk[depth-1] - 1 : h - 1;
        stk[depth++] = r;
      end
      for (int r = 0; r < h; r++) begin
        v = run_of(r, c, w);
        if (v != 0) begin
          ht = dn[r] - up[r] + 1;
          area = v * ht;
          idx = r * w + c;
          if (area > best || (area == best && idx < best_idx)) begin
            best = area;
            best_idx = idx;
            res.top = TOP_ROW_W'(up[r]);
            res.column = RIGHT_COL_W'(c);
            res.width = RECT_WIDTH_W'(v);
            res.height = RECT_HEIGHT_W'(ht);
            res.area = RECT_AREA_W'(area);
          end
        end
      end
    end
    return res;
  endfunction

  function void note_cell(bit open, bit last);
    int unsigned w, run;
    w = sat(width_reg, DEF_MAX_COLS);
    if (cells_loaded < w * sat(height_reg, DEF_MAX_ROWS)) begin
      run = 0;
      if (open) begin
        run = 1;
        if (cells_loaded % w != 0) run = run_len[cells_loaded-1] + 1;
        if (run > DEF_MAX_COLS) run = DEF_MAX_COLS;
      end
      run_len[cells_loaded] = run;
      cells_loaded++;
    end
    if (last) begin
      rect_q = {rect_q, largest_rect()};
      cells_loaded = 0;
    end
  endfunction

  function void check_rect(logic [OUT_DATA_W-1:0] data);
    rect_t got, exp;
    got = data[$bits(rect_t)-1:0];
    rects_seen++;
    if (got.area != 0) nonzero_seen++;
    if (rect_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result beat %h", data);
      return;
    end
    exp = rect_q.pop_front();
    if (got !== exp || data[OUT_DATA_W-1:$bits(rect_t)] !== '0) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch: exp top %0d col %0d w %0d h %0d area %0d",
                 exp.top, exp.column, exp.width, exp.height, exp.area);
        $display("          got top %0d col %0d w %0d h %0d area %0d",
                 got.top, got.column, got.width, got.height, got.area);
      end
    end
  endfunction

  function int unsigned pending();
    return rect_q.size();
  endfunction
endclass

module tb_largest_ones_rectangle_unit;
  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready, s_tlast = 0;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid, m_tready = 0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic cfg_we = 0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  rect_scoreboard sb = new();
  bit no_gaps = 0, rx_holdoff = 0;
  int unsigned cells_sent = 0, grids_sent = 0, quiet_cycles = 0;

  largest_ones_rectangle_unit uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (m_tvalid && m_tready) sb.check_rect(m_tdata);
    if (quiet_cycles > 400000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : receiver
    int unsigned gap;
    @(negedge rst);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 14);
      if (rx_holdoff) begin
        gap = 3000;
        rx_holdoff = 0;
      end
      if (gap > 0) begin
        m_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  task automatic send_cell(bit open, bit last);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {{(IN_DATA_W-1){1'b0}}, open};
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_cell(open, last);
    cells_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic set_size(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
    drain();
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    cfg_we <= 0;
  endtask

  // n cells, last on the final one; pct is the chance in percent of an open cell
  task automatic send_grid(int unsigned n, int unsigned pct);
    for (int unsigned i = 0; i < n; i++)
      send_cell($urandom_range(0, 99) < pct, i == n - 1);
    grids_sent++;
  endtask

  initial begin
    int unsigned cells, n, kind;
    logic [CFG_DATA_W-1:0] w, h;
    sb.clear();
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // default 64x64, early last
    send_cell(1, 0); send_cell(1, 0); send_cell(0, 1);
    // out-of-range registers saturate
    set_size(7'd127, 7'd0);
    send_cell(1, 0); send_cell(1, 0); send_cell(1, 0); send_cell(1, 1);
    set_size(7'd0, 7'd127);
    send_cell(1, 0); send_cell(0, 0); send_cell(1, 0); send_cell(1, 1);
    set_size(7'd2, 7'd2);
    send_cell(0, 0); send_cell(0, 0); send_cell(0, 0); send_cell(0, 1);
    send_cell(1, 0); send_cell(1, 0); send_cell(1, 0); send_cell(1, 1);
    // too many cells
    set_size(7'd2, 7'd1);
    send_cell(1, 0); send_cell(0, 0); send_cell(1, 0); send_cell(1, 1);

    // full-size geometry, ended after three rows
    set_size(7'd64, 7'd64);
    send_grid(192, 97);
    set_size(7'd6, 7'd5);

    while (cells_sent < 550) begin
      if ($urandom_range(0, 2) == 0) begin
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
        set_size(w, h);
      end
      if (grids_sent == 4) rx_holdoff = 1;
      if (grids_sent == 9) drain();
      no_gaps = ($urandom_range(0, 3) == 0);
      cells = sb.sat(sb.width_reg, DEF_MAX_COLS) * sb.sat(sb.height_reg, DEF_MAX_ROWS);
      kind = $urandom_range(0, 9);
      if (kind == 0) n = $urandom_range(1, cells);
      else if (kind == 1) n = cells + $urandom_range(1, 4);
      else n = cells;
      send_grid(n, $urandom_range(20, 100));
    end
    s_tvalid <= 0;
    no_gaps = 0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("%0d cells in %0d grids sent, %0d rectangles checked (%0d nonempty)",
             cells_sent, grids_sent + 6, sb.rects_seen, sb.nonzero_seen);
    $display("sizes up to 64x64 incl. saturated registers, early and overlong grids");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/lor_pkg.sv
hw/rtl/lor_ram.sv
hw/rtl/lor_ctrl.sv
hw/rtl/lor_datapath.sv
hw/rtl/largest_ones_rectangle_unit.sv
hw/rtl/lor_checker.sv
sim/tb_largest_ones_rectangle_unit.sv
